/* hw/rtl/nrg_pkg.sv */
// ----------------------------------------------------------------------------
// nrg_pkg: shared types and constants of the nonce replay guard
// Opcode and reason encodings, fixed field widths and the index-width helper.
// ----------------------------------------------------------------------------
package nrg_pkg;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_CHECK     = 2'd0,
      OP_SET_EPOCH = 2'd1,
      OP_FLUSH_CTX = 2'd2,
      OP_FLUSH_ALL = 2'd3
   } opcode_type;

   // Response reason codes
   typedef enum logic [2:0] {
      RSN_ACCEPT    = 3'd0,
      RSN_STALE     = 3'd1,
      RSN_REPLAY    = 3'd2,
      RSN_EPOCH_SET = 3'd3,
      RSN_FLUSHED   = 3'd4
   } reason_type;

   localparam int unsigned OPCODE_W     = 2;
   localparam int unsigned CTX_IN_W     = 3;
   localparam int unsigned EPOCH_W      = 32;
   localparam int unsigned NONCE_WORD_W = 64;
   localparam int unsigned SLOT_OUT_W   = 4;
   localparam int unsigned QUEUE_DEPTH  = 2;

   // Width of an index into n entries, never below one bit
   function automatic int unsigned idx_width(input int unsigned n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

/* hw/rtl/nrg_ram.sv */
// ----------------------------------------------------------------------------
// nrg_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module nrg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [nrg_pkg::idx_width(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [nrg_pkg::idx_width(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read into the registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nrg_front.sv */
// ----------------------------------------------------------------------------
// nrg_front: request intake and classification
// Registers each request, decodes the opcode, folds the context onto the
// configured context count and keeps only the stored nonce words.
// ----------------------------------------------------------------------------
module nrg_front #(
   parameter int unsigned CONTEXTS    = 8,
   parameter int unsigned NONCE_WORDS = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [nrg_pkg::OPCODE_W-1:0]            req_opcode,
   input  logic [nrg_pkg::CTX_IN_W-1:0]            req_context_id,
   input  logic [nrg_pkg::EPOCH_W-1:0]             req_epoch,
   input  logic [nrg_pkg::NONCE_WORD_W-1:0]        req_nonce_word0,
   input  logic [nrg_pkg::NONCE_WORD_W-1:0]        req_nonce_word1,
   input  logic [nrg_pkg::NONCE_WORD_W-1:0]        req_nonce_word2,
   input  logic [nrg_pkg::NONCE_WORD_W-1:0]        req_nonce_word3,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output nrg_pkg::opcode_type                     out_op,
   output logic [nrg_pkg::idx_width(CONTEXTS)-1:0] out_ctx,
   output logic [nrg_pkg::EPOCH_W-1:0]             out_epoch,
   output logic [NONCE_WORDS*nrg_pkg::NONCE_WORD_W-1:0] out_nonce
);

   localparam int unsigned CW         = nrg_pkg::idx_width(CONTEXTS);
   localparam int unsigned NONCE_BITS = NONCE_WORDS * nrg_pkg::NONCE_WORD_W;
   localparam int unsigned ALL_BITS   = 4 * nrg_pkg::NONCE_WORD_W;
   localparam int unsigned CTX_STEP   = CONTEXTS % 16;

   logic                            valid_ff;
   logic                            valid_in;
   nrg_pkg::opcode_type             op_ff;
   nrg_pkg::opcode_type             op_in;
   logic [CW-1:0]                   ctx_ff;
   logic [CW-1:0]                   ctx_in;
   logic [nrg_pkg::EPOCH_W-1:0]     epoch_ff;
   logic [NONCE_BITS-1:0]           nonce_ff;
   logic [NONCE_BITS-1:0]           nonce_in;
   logic [ALL_BITS-1:0]             nonce_all;
   logic [3:0]                      ctx_work;
   logic                            take;

   assign req_ready = !valid_ff || out_ready;
   assign take      = req_valid && req_ready;

   // Fold the context onto the context count by repeated subtraction
   always_comb begin
      ctx_work = {1'b0, req_context_id};
      for (int k = 0; k < 8; k++) begin
         if (CONTEXTS < 8 && ctx_work >= 4'(CTX_STEP)) begin
            ctx_work = ctx_work - 4'(CTX_STEP);
         end
      end
      ctx_in = CW'(ctx_work);
   end

   // Decode opcode and keep the stored nonce words
   assign op_in     = nrg_pkg::opcode_type'(req_opcode);
   assign nonce_all = {req_nonce_word3, req_nonce_word2, req_nonce_word1, req_nonce_word0};
   assign nonce_in  = nonce_all[NONCE_BITS-1:0];

   // Hold the request until the queue takes it
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= op_in;
         ctx_ff   <= ctx_in;
         epoch_ff <= req_epoch;
         nonce_ff <= nonce_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_ctx   = ctx_ff;
   assign out_epoch = epoch_ff;
   assign out_nonce = nonce_ff;

endmodule

/* hw/rtl/nrg_queue.sv */
// ----------------------------------------------------------------------------
// nrg_queue: short request queue between front and back
// A small FIFO that lets intake and table processing stall independently.
// ----------------------------------------------------------------------------
module nrg_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PW = nrg_pkg::idx_width(nrg_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(nrg_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [nrg_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(nrg_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/nrg_back.sv */
// ----------------------------------------------------------------------------
// nrg_back: nonce table, epoch floors and response register
// Matches a request against every entry in the lookup state, then decides,
// writes the table back and loads the response register in the commit state.
// ----------------------------------------------------------------------------
module nrg_back #(
   parameter int unsigned ENTRIES     = 16,
   parameter int unsigned CONTEXTS    = 8,
   parameter int unsigned NONCE_WORDS = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  nrg_pkg::opcode_type                     in_op,
   input  logic [nrg_pkg::idx_width(CONTEXTS)-1:0] in_ctx,
   input  logic [nrg_pkg::EPOCH_W-1:0]             in_epoch,
   input  logic [NONCE_WORDS*nrg_pkg::NONCE_WORD_W-1:0] in_nonce,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_accepted,
   output logic [2:0]                              rsp_reason_code,
   output logic [nrg_pkg::SLOT_OUT_W-1:0]          rsp_slot_index
);

   localparam int unsigned CW         = nrg_pkg::idx_width(CONTEXTS);
   localparam int unsigned SW         = nrg_pkg::idx_width(ENTRIES);
   localparam int unsigned NONCE_BITS = NONCE_WORDS * nrg_pkg::NONCE_WORD_W;

   typedef enum logic [1:0] {
      ST_LOOKUP = 2'b01,
      ST_COMMIT = 2'b10
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   logic [ENTRIES-1:0]           entry_valid_ff;
   logic [ENTRIES-1:0]           entry_valid_in;
   logic [CW-1:0]                entry_ctx_ff   [ENTRIES];
   logic [nrg_pkg::EPOCH_W-1:0]  entry_epoch_ff [ENTRIES];
   logic [NONCE_BITS-1:0]        entry_nonce_ff [ENTRIES];
   logic [ENTRIES-1:0]           match_ff;
   logic [ENTRIES-1:0]           match_in;
   logic [SW-1:0]                victim_ff;
   logic [SW-1:0]                victim_in;
   logic [CONTEXTS-1:0]          floor_valid_ff;
   logic [CONTEXTS-1:0]          floor_valid_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_accepted_ff;
   nrg_pkg::reason_type          rsp_reason_ff;
   logic [nrg_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;

   logic [nrg_pkg::EPOCH_W-1:0]  floor_rd;
   logic [nrg_pkg::EPOCH_W-1:0]  floor_val;
   logic                         out_free;
   logic                         commit;
   logic                         lookup;
   logic                         stale;
   logic                         any_match;
   logic                         full;
   logic [SW-1:0]                match_idx;
   logic [SW-1:0]                free_idx;
   logic [SW-1:0]                target;
   logic                         dec_accepted;
   nrg_pkg::reason_type          dec_reason;
   logic [SW-1:0]                dec_slot;
   logic                         dec_store;
   logic                         dec_advance;
   logic                         dec_floor_we;
   logic                         dec_drop_ctx;
   logic                         dec_drop_all;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign lookup   = (state_ff == ST_LOOKUP) && in_valid;
   assign commit   = (state_ff == ST_COMMIT) && out_free;
   assign in_ready = commit;

   // Epoch floor store: read during lookup, written at commit
   nrg_ram #(
      .WIDTH (nrg_pkg::EPOCH_W),
      .DEPTH (CONTEXTS)
   ) u_floor_ram (
      .clock   (clock),
      .wr_en   (commit && dec_floor_we),
      .wr_addr (in_ctx),
      .wr_data (in_epoch),
      .rd_en   (lookup),
      .rd_addr (in_ctx),
      .rd_data (floor_rd)
   );

   // Compare the request against every entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = entry_valid_ff[i] && (entry_ctx_ff[i] == in_ctx)
                       && (entry_epoch_ff[i] == in_epoch)
                       && (entry_nonce_ff[i] == in_nonce);
      end
   end

   // Find lowest matching and lowest free slots
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            match_idx = SW'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_idx = SW'(i);
         end
      end
   end

   assign floor_val = floor_valid_ff[in_ctx] ? floor_rd : '0;
   assign stale     = (in_epoch < floor_val);
   assign any_match = |match_ff;
   assign full      = &entry_valid_ff;
   assign target    = full ? victim_ff : free_idx;

   // Decide the outcome of the request at the queue head
   always_comb begin
      dec_accepted = 1'b1;
      dec_reason   = nrg_pkg::RSN_ACCEPT;
      dec_slot     = '0;
      dec_store    = 1'b0;
      dec_advance  = 1'b0;
      dec_floor_we = 1'b0;
      dec_drop_ctx = 1'b0;
      dec_drop_all = 1'b0;
      unique case (in_op)
         nrg_pkg::OP_CHECK: begin
            if (stale) begin
               dec_accepted = 1'b0;
               dec_reason   = nrg_pkg::RSN_STALE;
            end else if (any_match) begin
               dec_accepted = 1'b0;
               dec_reason   = nrg_pkg::RSN_REPLAY;
               dec_slot     = match_idx;
            end else begin
               dec_store   = 1'b1;
               dec_slot    = target;
               dec_advance = full;
            end
         end
         nrg_pkg::OP_SET_EPOCH: begin
            dec_reason   = nrg_pkg::RSN_EPOCH_SET;
            dec_floor_we = 1'b1;
            dec_drop_ctx = 1'b1;
         end
         nrg_pkg::OP_FLUSH_CTX: begin
            dec_reason   = nrg_pkg::RSN_FLUSHED;
            dec_drop_ctx = 1'b1;
         end
         nrg_pkg::OP_FLUSH_ALL: begin
            dec_reason   = nrg_pkg::RSN_FLUSHED;
            dec_drop_all = 1'b1;
         end
         default: begin
            dec_reason = nrg_pkg::RSN_FLUSHED;
         end
      endcase
   end

   // Update valid bits, victim pointer and floor valid bits
   always_comb begin
      entry_valid_in = entry_valid_ff;
      victim_in      = victim_ff;
      floor_valid_in = floor_valid_ff;
      if (commit) begin
         if (dec_drop_all) begin
            entry_valid_in = '0;
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (dec_drop_ctx && entry_ctx_ff[i] == in_ctx) begin
               entry_valid_in[i] = 1'b0;
            end
         end
         if (dec_store) begin
            entry_valid_in[target] = 1'b1;
         end
         if (dec_advance) begin
            victim_in = (victim_ff == SW'(ENTRIES - 1)) ? '0 : victim_ff + 1'b1;
         end
         if (dec_floor_we) begin
            floor_valid_in[in_ctx] = 1'b1;
         end
      end
   end

   // Sequence lookup and commit
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOOKUP: begin
            if (in_valid) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_LOOKUP;
            end
         end
         default: begin
            state_in = ST_LOOKUP;
         end
      endcase
   end

   // Hold the response until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOOKUP;
         entry_valid_ff <= '0;
         victim_ff      <= '0;
         floor_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         victim_ff      <= victim_in;
         floor_valid_ff <= floor_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Table payload, match vector and response fields
   always_ff @(posedge clock) begin
      if (lookup) begin
         match_ff <= match_in;
      end
      if (commit && dec_store) begin
         entry_ctx_ff[target]   <= in_ctx;
         entry_epoch_ff[target] <= in_epoch;
         entry_nonce_ff[target] <= in_nonce;
      end
      if (commit) begin
         rsp_accepted_ff <= dec_accepted;
         rsp_reason_ff   <= dec_reason;
         rsp_slot_ff     <= nrg_pkg::SLOT_OUT_W'(dec_slot);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_reason_code = rsp_reason_ff;
   assign rsp_slot_index  = rsp_slot_ff;

endmodule

/* hw/rtl/nonce_replay_guard.sv */
// ----------------------------------------------------------------------------
// nonce_replay_guard: anti-replay nonce cache
// Checks (context, epoch, nonce) requests against a table of recent nonces.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (valid/ready): an opcode (check, set epoch
//   floor, flush context, flush all), a context, an epoch and the nonce
//   words. Each request gives exactly one response on rsp_* (valid/ready):
//   accepted flag, reason code and slot index, in request order.
//   A request passes the input register, the queue, the table engine's
//   lookup and commit states and the response register. Each request
//   occupies the table engine for a lookup step, the parallel match over
//   all entries and the epoch floor read, and a commit step, the decision
//   and table write-back; the engine takes no new request until it commits.
//   An input register and a two-entry queue sit in front of the table
//   engine, so intake carries on while the engine or the receiver stalls.
//   A stalled receiver holds the response register; the engine then waits
//   and the queue fills before req_ready drops.
//   Reset clears all valid bits, the epoch floors (to zero) and the victim
//   pointer; the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module nonce_replay_guard #(
   parameter int unsigned ENTRIES     = 16,
   parameter int unsigned CONTEXTS    = 8,
   parameter int unsigned NONCE_WORDS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_context_id,
   input  logic [31:0] req_epoch,
   input  logic [63:0] req_nonce_word0,
   input  logic [63:0] req_nonce_word1,
   input  logic [63:0] req_nonce_word2,
   input  logic [63:0] req_nonce_word3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_reason_code,
   output logic [3:0]  rsp_slot_index
);

   localparam int unsigned CW         = nrg_pkg::idx_width(CONTEXTS);
   localparam int unsigned NONCE_BITS = NONCE_WORDS * nrg_pkg::NONCE_WORD_W;
   localparam int unsigned ITEM_W     = nrg_pkg::OPCODE_W + CW + nrg_pkg::EPOCH_W
                                        + NONCE_BITS;

   logic                         fr_valid;
   logic                         fr_ready;
   nrg_pkg::opcode_type          fr_op;
   logic [CW-1:0]                fr_ctx;
   logic [nrg_pkg::EPOCH_W-1:0]  fr_epoch;
   logic [NONCE_BITS-1:0]        fr_nonce;
   logic [ITEM_W-1:0]            q_push_data;
   logic [ITEM_W-1:0]            q_pop_data;
   logic                         q_valid;
   logic                         q_ready;
   nrg_pkg::opcode_type          bk_op;
   logic [CW-1:0]                bk_ctx;
   logic [nrg_pkg::EPOCH_W-1:0]  bk_epoch;
   logic [NONCE_BITS-1:0]        bk_nonce;

   // Request intake
   nrg_front #(
      .CONTEXTS    (CONTEXTS),
      .NONCE_WORDS (NONCE_WORDS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_context_id  (req_context_id),
      .req_epoch       (req_epoch),
      .req_nonce_word0 (req_nonce_word0),
      .req_nonce_word1 (req_nonce_word1),
      .req_nonce_word2 (req_nonce_word2),
      .req_nonce_word3 (req_nonce_word3),
      .out_valid       (fr_valid),
      .out_ready       (fr_ready),
      .out_op          (fr_op),
      .out_ctx         (fr_ctx),
      .out_epoch       (fr_epoch),
      .out_nonce       (fr_nonce)
   );

   // Pack and unpack the queued request
   assign q_push_data = {fr_op, fr_ctx, fr_epoch, fr_nonce};
   assign bk_op       = nrg_pkg::opcode_type'(q_pop_data[ITEM_W-1 -: nrg_pkg::OPCODE_W]);
   assign bk_ctx      = q_pop_data[NONCE_BITS + nrg_pkg::EPOCH_W +: CW];
   assign bk_epoch    = q_pop_data[NONCE_BITS +: nrg_pkg::EPOCH_W];
   assign bk_nonce    = q_pop_data[NONCE_BITS-1:0];

   nrg_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_pop_data)
   );

   // Table engine and response register
   nrg_back #(
      .ENTRIES     (ENTRIES),
      .CONTEXTS    (CONTEXTS),
      .NONCE_WORDS (NONCE_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_op           (bk_op),
      .in_ctx          (bk_ctx),
      .in_epoch        (bk_epoch),
      .in_nonce        (bk_nonce),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_reason_code (rsp_reason_code),
      .rsp_slot_index  (rsp_slot_index)
   );

endmodule
